// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for the concurrent checks used in the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

// File: design/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// types, field widths and the warm-range duty table of the pump controller
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int ECHO_W     = 20;
   localparam int DIST_W     = 15;
   localparam int PERCENT_W  = 7;
   localparam int LIGHT_W    = 8;
   localparam int DUTY_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // floor(echo*17/1000) as one reciprocal multiply, exact for 20-bit echo
   localparam int DIST_X_W          = ECHO_W + 5;
   localparam int DIST_SHIFT        = DIST_X_W + 10;
   localparam longint unsigned DIST_RECIP =
      17 * (((64'd1 << DIST_SHIFT) + 64'd999) / 64'd1000);
   localparam int DIST_RECIP_W      = DIST_X_W + 6;
   localparam int DIST_PROD_W       = ECHO_W + DIST_RECIP_W;

   localparam int MOIST_SCALE = 116;
   localparam int LIGHT_SCALE = 111;
   localparam int LIGHT_OFFSET = 5;
   localparam int TEMP_SCALE  = 500;
   localparam int WARM_BASE   = 60;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DRY_SOIL    = 3'd0,
      REG_LOW_WATER   = 3'd1,
      REG_REFILL_STOP = 3'd2,
      REG_DIM_LIGHT   = 3'd3,
      REG_COLD_DUTY   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      BUZ_OFF = 2'd0,
      BUZ_DRY = 2'd1,
      BUZ_LOW = 2'd2
   } buzzer_type;

   typedef struct packed {
      logic [DUTY_W-1:0]           pump_duty;
      logic                        green_on;
      logic                        yellow_on;
      logic                        red_on;
      buzzer_type                  buzzer_mode;
      logic                        refill_on;
      logic [PERCENT_W-1:0]        moisture_percent;
      logic signed [LIGHT_W-1:0]   light_percent;
      logic [DIST_W-1:0]           distance_cm;
      logic                        low_water;
   } result_type;

   // 128 + floor(step*127/20) for step 0..20 degrees above ten
   function automatic logic [DUTY_W-1:0] warm_duty(input logic [4:0] step);
      logic [DUTY_W-1:0] d;
      case (step)
         5'd0:    d = 8'd128;
         5'd1:    d = 8'd134;
         5'd2:    d = 8'd140;
         5'd3:    d = 8'd147;
         5'd4:    d = 8'd153;
         5'd5:    d = 8'd159;
         5'd6:    d = 8'd166;
         5'd7:    d = 8'd172;
         5'd8:    d = 8'd178;
         5'd9:    d = 8'd185;
         5'd10:   d = 8'd191;
         5'd11:   d = 8'd197;
         5'd12:   d = 8'd204;
         5'd13:   d = 8'd210;
         5'd14:   d = 8'd216;
         5'd15:   d = 8'd223;
         5'd16:   d = 8'd229;
         5'd17:   d = 8'd235;
         5'd18:   d = 8'd242;
         5'd19:   d = 8'd248;
         default: d = 8'd255;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// File: design/ipc_if.sv
// ----------------------------------------------------------------------------
// ipc channel interfaces
// sample-set request channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface ipc_req_if import ipc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] soil_raw;
   logic [SAMPLE_W-1:0] temp_raw;
   logic [ECHO_W-1:0]   echo_us;
   logic [SAMPLE_W-1:0] light_raw;

   modport source (output valid, soil_raw, temp_raw, echo_us, light_raw, input ready);
   modport sink   (input valid, soil_raw, temp_raw, echo_us, light_raw, output ready);
endinterface

interface ipc_rsp_if import ipc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [DUTY_W-1:0]         pump_duty;
   logic                      green_on;
   logic                      yellow_on;
   logic                      red_on;
   logic [1:0]                buzzer_mode;
   logic                      refill_on;
   logic [PERCENT_W-1:0]      moisture_percent;
   logic signed [LIGHT_W-1:0] light_percent;
   logic [DIST_W-1:0]         distance_cm;
   logic                      low_water;

   modport source (output valid, pump_duty, green_on, yellow_on, red_on, buzzer_mode,
                   refill_on, moisture_percent, light_percent, distance_cm, low_water,
                   input ready);
   modport sink   (input valid, pump_duty, green_on, yellow_on, red_on, buzzer_mode,
                   refill_on, moisture_percent, light_percent, distance_cm, low_water,
                   output ready);
endinterface

`default_nettype wire

// File: design/irrigation_pump_controller.sv
// ----------------------------------------------------------------------------
// irrigation_pump_controller
// scales one sensor sample set per beat and drives pump duty, indicators,
// buzzer mode and the refill pump with hysteresis
// ----------------------------------------------------------------------------
// One result beat per request beat, in order. A request is registered in the
// input stage, worked through constant-reciprocal multiplies and compares,
// and the result is registered in the result stage; a new sample set is taken
// every cycle and throughput is one beat per clock, limited only by the result
// register draining. The refill pump state advances once per item as it moves
// into the result register. Threshold registers reset to 40 % dry, 200 cm low
// water, 30 cm refill stop, 30 % dim light and a cold duty of 55, and should
// be written only while no item is in flight.
`default_nettype none
`include "assert_macros.svh"

module irrigation_pump_controller import ipc_pkg::*; #(
   parameter int ADC_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ipc_req_if.sink                    req_ch,
   ipc_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam longint unsigned ADC_MAX = (64'd1 << ADC_BITS) - 64'd1;

   // percent scaling: x < 2^PCT_X_W, exact reciprocal of the full scale
   localparam int PCT_X_W   = ADC_BITS + 7;
   localparam int PCT_SHIFT = PCT_X_W + ADC_BITS;
   localparam longint unsigned PCT_RECIP =
      ((64'd1 << PCT_SHIFT) + ADC_MAX - 64'd1) / ADC_MAX;
   localparam int PCT_PROD_W = 2 * PCT_X_W + 1;

   // temperature: floor(raw*500/full scale) folded into one constant
   localparam int TEMP_X_W   = ADC_BITS + 9;
   localparam int TEMP_SHIFT = TEMP_X_W + ADC_BITS;
   localparam longint unsigned TEMP_RECIP =
      TEMP_SCALE * (((64'd1 << TEMP_SHIFT) + ADC_MAX - 64'd1) / ADC_MAX);
   localparam int TEMP_RECIP_W = TEMP_X_W + 10;
   localparam int TEMP_PROD_W  = ADC_BITS + TEMP_RECIP_W;

   // raw*500 <= 60*fs (resp. 80*fs) reduced to a compare on the raw sample
   localparam logic [ADC_BITS-1:0] COLD_LIMIT =
      ADC_BITS'((60 * ADC_MAX) / TEMP_SCALE);
   localparam logic [ADC_BITS-1:0] WARM_LIMIT =
      ADC_BITS'((80 * ADC_MAX) / TEMP_SCALE);

   // configuration
   logic [PERCENT_W-1:0]      dry_soil_ff;
   logic [DIST_W-1:0]         low_water_ff;
   logic [DIST_W-1:0]         refill_stop_ff;
   logic signed [LIGHT_W-1:0] dim_light_ff;
   logic [DUTY_W-1:0]         cold_duty_ff;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0] soil_ff, temp_ff, light_ff;
   logic [ECHO_W-1:0]   echo_ff;

   // result stage
   logic       s2_valid_ff, s2_valid_in;
   result_type result_ff, result_in;
   logic       refill_ff, refill_in;

   logic req_take, advance;

   // datapath
   logic [ADC_BITS-1:0]       soil_s, temp_s, light_s;
   logic [PCT_X_W-1:0]        moist_x, light_x;
   logic [PCT_PROD_W-1:0]     moist_p, light_p;
   logic [PERCENT_W-1:0]      moist_q, light_q, moist;
   logic signed [LIGHT_W-1:0] light_pct;
   logic [TEMP_PROD_W-1:0]    temp_p;
   logic [8:0]                temp_q;
   logic [4:0]                warm_step;
   logic [DIST_PROD_W-1:0]    dist_p;
   logic [DIST_W-1:0]         dist_cm;
   logic                      low, dry, cold, hot;
   logic [DUTY_W-1:0]         base_duty, duty;

   assign advance       = s1_valid_ff && (!s2_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || advance;
   assign req_take      = req_ch.valid && req_ch.ready;
   assign s1_valid_in   = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign s2_valid_in   = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_soil_ff    <= 7'd40;
         low_water_ff   <= 15'd200;
         refill_stop_ff <= 15'd30;
         dim_light_ff   <= 8'sd30;
         cold_duty_ff   <= 8'd55;
      end else if (csr_we) begin
         case (csr_index)
            REG_DRY_SOIL:    dry_soil_ff    <= csr_wdata[PERCENT_W-1:0];
            REG_LOW_WATER:   low_water_ff   <= csr_wdata[DIST_W-1:0];
            REG_REFILL_STOP: refill_stop_ff <= csr_wdata[DIST_W-1:0];
            REG_DIM_LIGHT:   dim_light_ff   <= $signed(csr_wdata[LIGHT_W-1:0]);
            REG_COLD_DUTY:   cold_duty_ff   <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         refill_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (advance) begin
            refill_ff <= refill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         soil_ff  <= req_ch.soil_raw;
         temp_ff  <= req_ch.temp_raw;
         echo_ff  <= req_ch.echo_us;
         light_ff <= req_ch.light_raw;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   always_comb begin
      soil_s  = ADC_BITS'(soil_ff);
      temp_s  = ADC_BITS'(temp_ff);
      light_s = ADC_BITS'(light_ff);

      moist_x = PCT_X_W'(ADC_BITS'(ADC_MAX) - soil_s) * PCT_X_W'(MOIST_SCALE);
      moist_p = PCT_PROD_W'(moist_x) * PCT_PROD_W'(PCT_RECIP);
      moist_q = moist_p[PCT_SHIFT +: PERCENT_W];
      moist   = PERCENT_W'(MOIST_SCALE) - moist_q;

      light_x   = PCT_X_W'(light_s) * PCT_X_W'(LIGHT_SCALE);
      light_p   = PCT_PROD_W'(light_x) * PCT_PROD_W'(PCT_RECIP);
      light_q   = light_p[PCT_SHIFT +: PERCENT_W];
      light_pct = $signed({1'b0, light_q}) - LIGHT_W'(LIGHT_OFFSET);

      dist_p  = DIST_PROD_W'(echo_ff) * DIST_PROD_W'(DIST_RECIP);
      dist_cm = dist_p[DIST_SHIFT +: DIST_W];

      temp_p    = TEMP_PROD_W'(temp_s) * TEMP_PROD_W'(TEMP_RECIP);
      temp_q    = temp_p[TEMP_SHIFT +: 9];
      warm_step = 5'(temp_q - 9'(WARM_BASE));
      cold      = temp_s <= COLD_LIMIT;
      hot       = !(temp_s <= WARM_LIMIT);

      if (cold) begin
         base_duty = cold_duty_ff;
      end else if (hot) begin
         base_duty = 8'd255;
      end else begin
         base_duty = warm_duty(warm_step);
      end
      duty = (light_pct < dim_light_ff) ? (base_duty >> 1) : base_duty;

      low = dist_cm > low_water_ff;
      dry = moist < dry_soil_ff;

      // on test wins when the thresholds cross
      if (low) begin
         refill_in = 1'b1;
      end else if (dist_cm < refill_stop_ff) begin
         refill_in = 1'b0;
      end else begin
         refill_in = refill_ff;
      end

      result_in                  = '0;
      result_in.refill_on        = refill_in;
      result_in.moisture_percent = moist;
      result_in.light_percent    = light_pct;
      result_in.distance_cm      = dist_cm;
      result_in.low_water        = low;
      result_in.buzzer_mode      = BUZ_OFF;
      if (dry && !low) begin
         result_in.pump_duty   = duty;
         result_in.red_on      = 1'b1;
         result_in.buzzer_mode = BUZ_DRY;
      end else if (low) begin
         result_in.yellow_on   = 1'b1;
         result_in.buzzer_mode = BUZ_LOW;
         result_in.red_on      = dry;
         result_in.green_on    = !dry;
      end else begin
         result_in.green_on    = 1'b1;
      end
   end

   assign rsp_ch.valid            = s2_valid_ff;
   assign rsp_ch.pump_duty        = result_ff.pump_duty;
   assign rsp_ch.green_on         = result_ff.green_on;
   assign rsp_ch.yellow_on        = result_ff.yellow_on;
   assign rsp_ch.red_on           = result_ff.red_on;
   assign rsp_ch.buzzer_mode      = result_ff.buzzer_mode;
   assign rsp_ch.refill_on        = result_ff.refill_on;
   assign rsp_ch.moisture_percent = result_ff.moisture_percent;
   assign rsp_ch.light_percent    = result_ff.light_percent;
   assign rsp_ch.distance_cm      = result_ff.distance_cm;
   assign rsp_ch.low_water        = result_ff.low_water;

   // a low tank always forces the refill pump on and lights yellow
   `ASSERT_IMPLY(a_low_refill, clock, reset, s2_valid_ff && result_ff.low_water,
                 result_ff.refill_on && result_ff.yellow_on)
   // nonzero duty only while irrigating
   `ASSERT_IMPLY(a_duty_irrigating, clock, reset,
                 s2_valid_ff && (result_ff.pump_duty != '0),
                 result_ff.red_on && !result_ff.green_on && !result_ff.low_water
                 && (result_ff.buzzer_mode == BUZ_DRY))
   // hysteresis state moves only with an item
   `ASSERT_NEXT(a_refill_hold, clock, reset, !advance, $stable(refill_ff))

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the irrigation pump controller: sample sets go in
// over the request channel, each result beat is checked field by field
// against an in-bench prediction of duty, indicators, buzzer, refill pump and
// scaled readings, across several threshold settings and stall patterns
// ----------------------------------------------------------------------------
module tb_top;
   import ipc_pkg::*;

   localparam int ADC_FULL     = (1 << SAMPLE_W) - 1;
   localparam int ECHO_MAX     = (1 << ECHO_W) - 1;
   localparam int DIST_MAX     = 17825;
   localparam int NUM_REGS     = 5;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 92;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] soil_raw;
      logic [SAMPLE_W-1:0] temp_raw;
      logic [ECHO_W-1:0]   echo_us;
      logic [SAMPLE_W-1:0] light_raw;
   } sample_set_type;

   class pump_scoreboard;
      int unsigned dry_pct, low_cm, stop_cm, cold_duty;
      int          dim_pct;
      bit          refill_state;
      result_type  expected_controls[$];
      int unsigned n_checked, n_fail;

      function new();
         dry_pct      = 40;
         low_cm       = 200;
         stop_cm      = 30;
         dim_pct      = 30;
         cold_duty    = 55;
         refill_state = 1'b0;
         n_checked    = 0;
         n_fail       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_DRY_SOIL:    dry_pct   = data[PERCENT_W-1:0];
            REG_LOW_WATER:   low_cm    = data;
            REG_REFILL_STOP: stop_cm   = data;
            REG_DIM_LIGHT:   dim_pct   = int'($signed(data[LIGHT_W-1:0]));
            REG_COLD_DUTY:   cold_duty = data[DUTY_W-1:0];
            default: ;
         endcase
      endfunction

      function result_type predict_controls(sample_set_type s);
         result_type  r;
         int unsigned moist, dist_cm, heat, deg, duty;
         int          light;
         bit          dry, low;
         moist   = MOIST_SCALE - ((ADC_FULL - s.soil_raw) * MOIST_SCALE) / ADC_FULL;
         light   = int'((s.light_raw * LIGHT_SCALE) / ADC_FULL) - LIGHT_OFFSET;
         dist_cm = (s.echo_us * 17) / 1000;
         low     = dist_cm > low_cm;
         dry     = moist < dry_pct;
         // temperature band picked on temp*500 against ten and thirty degree marks
         heat = s.temp_raw * TEMP_SCALE;
         if (heat <= WARM_BASE * ADC_FULL) begin
            duty = cold_duty;
         end else if (heat <= (WARM_BASE + 20) * ADC_FULL) begin
            deg  = heat / ADC_FULL - 50;
            duty = (deg - 10) * 127 / 20 + 128;
         end else begin
            duty = 255;
         end
         if (light < dim_pct) duty = duty >> 1;
         r = '0;
         r.buzzer_mode = BUZ_OFF;
         if (dry && !low) begin
            r.pump_duty   = duty[DUTY_W-1:0];
            r.red_on      = 1'b1;
            r.buzzer_mode = BUZ_DRY;
         end else if (low) begin
            r.yellow_on   = 1'b1;
            r.buzzer_mode = BUZ_LOW;
            r.red_on      = dry;
            r.green_on    = !dry;
         end else begin
            r.green_on = 1'b1;
         end
         // hysteresis, the on test wins when thresholds cross
         if (low) refill_state = 1'b1;
         else if (dist_cm < stop_cm) refill_state = 1'b0;
         r.refill_on        = refill_state;
         r.moisture_percent = moist[PERCENT_W-1:0];
         r.light_percent    = light[LIGHT_W-1:0];
         r.distance_cm      = dist_cm[DIST_W-1:0];
         r.low_water        = low;
         return r;
      endfunction

      function void note_sample(sample_set_type s);
         expected_controls.push_back(predict_controls(s));
      endfunction

      function string show(result_type r);
         return $sformatf({"duty=%0d g=%0b y=%0b r=%0b buz=%0d refill=%0b",
                           " moist=%0d light=%0d dist=%0d low=%0b"},
                          r.pump_duty, r.green_on, r.yellow_on, r.red_on, r.buzzer_mode,
                          r.refill_on, r.moisture_percent, r.light_percent, r.distance_cm,
                          r.low_water);
      endfunction

      function void check_result(result_type got);
         result_type want;
         string      diffs;
         if (expected_controls.size() == 0) begin
            n_fail++;
            if (n_fail <= REPORT_MAX) $display("unexpected result beat: %s", show(got));
            return;
         end
         want = expected_controls.pop_front();
         n_checked++;
         diffs = "";
         if (got.pump_duty !== want.pump_duty)               diffs = {diffs, " pump_duty"};
         if (got.green_on !== want.green_on)                 diffs = {diffs, " green_on"};
         if (got.yellow_on !== want.yellow_on)               diffs = {diffs, " yellow_on"};
         if (got.red_on !== want.red_on)                     diffs = {diffs, " red_on"};
         if (got.buzzer_mode !== want.buzzer_mode)           diffs = {diffs, " buzzer_mode"};
         if (got.refill_on !== want.refill_on)               diffs = {diffs, " refill_on"};
         if (got.moisture_percent !== want.moisture_percent) diffs = {diffs, " moisture_percent"};
         if (got.light_percent !== want.light_percent)       diffs = {diffs, " light_percent"};
         if (got.distance_cm !== want.distance_cm)           diffs = {diffs, " distance_cm"};
         if (got.low_water !== want.low_water)               diffs = {diffs, " low_water"};
         if (diffs != "") begin
            n_fail++;
            if (n_fail <= REPORT_MAX) begin
               $display("result %0d mismatch on%s", n_checked, diffs);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ipc_req_if req_bus ();
   ipc_rsp_if rsp_bus ();

   pump_scoreboard sb;
   int unsigned    sender_gap_pct, receiver_gap_pct;
   int unsigned    n_sent, n_settings;
   int unsigned    cycles = 0;
   int             dist_walk;

   irrigation_pump_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= receiver_gap_pct);
   end

   // input beats
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_sample({req_bus.soil_raw, req_bus.temp_raw, req_bus.echo_us,
                         req_bus.light_raw});
   end

   // result beats
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result({rsp_bus.pump_duty, rsp_bus.green_on, rsp_bus.yellow_on,
                          rsp_bus.red_on, buzzer_type'(rsp_bus.buzzer_mode),
                          rsp_bus.refill_on, rsp_bus.moisture_percent,
                          rsp_bus.light_percent, rsp_bus.distance_cm, rsp_bus.low_water});
   end

   task automatic send_sample(input int soil, input int temp, input int echo, input int light);
      if ($urandom_range(99) < sender_gap_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_bus.valid     <= 1'b1;
      req_bus.soil_raw  <= soil[SAMPLE_W-1:0];
      req_bus.temp_raw  <= temp[SAMPLE_W-1:0];
      req_bus.echo_us   <= echo[ECHO_W-1:0];
      req_bus.light_raw <= light[SAMPLE_W-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n_sent++;
   endtask

   // wait until every sent beat has come back and been checked
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.n_checked != n_sent) @(posedge clock);
   endtask

   // all five thresholds plus one write to an unused index, random filler above
   // each register's width
   task automatic apply_settings(input int dry, input int low, input int stop,
                                 input int dim, input int cold);
      int                    vals[NUM_REGS];
      logic [CSR_DATA_W-1:0] data;
      logic [CSR_IDX_W-1:0]  idx;
      vals = '{dry, low, stop, dim, cold};
      for (int i = 0; i <= NUM_REGS; i++) begin
         if (i < NUM_REGS) idx = CSR_IDX_W'(i);
         else idx = CSR_IDX_W'($urandom_range(NUM_REGS, (1 << CSR_IDX_W) - 1));
         data = CSR_DATA_W'($urandom);
         case (idx)
            REG_DRY_SOIL:                   data[PERCENT_W-1:0] = vals[i][PERCENT_W-1:0];
            REG_LOW_WATER, REG_REFILL_STOP: data = vals[i][CSR_DATA_W-1:0];
            REG_DIM_LIGHT, REG_COLD_DUTY:   data[DUTY_W-1:0] = vals[i][DUTY_W-1:0];
            default: ;
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         @(posedge clock);
         sb.write_reg(idx, data);
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   function automatic int clamp_sample(int v);
      if (v < 0) return 0;
      if (v > ADC_FULL) return ADC_FULL;
      return v;
   endfunction

   task automatic send_random_sample();
      int soil, temp, echo, light, span;
      span = ((sb.low_cm > sb.stop_cm) ? sb.low_cm : sb.stop_cm) + 60;
      if (span > DIST_MAX) span = DIST_MAX;
      if ($urandom_range(1)) soil = $urandom_range(0, ADC_FULL);
      else soil = clamp_sample(sb.dry_pct * ADC_FULL / MOIST_SCALE + $urandom_range(0, 24) - 12);
      if ($urandom_range(4) < 2) temp = $urandom_range(110, 175);
      else temp = $urandom_range(0, ADC_FULL);
      if ($urandom_range(1)) light = $urandom_range(0, ADC_FULL);
      else light = clamp_sample((sb.dim_pct + LIGHT_OFFSET) * ADC_FULL / LIGHT_SCALE
                                + $urandom_range(0, 20) - 10);
      // distance mostly wanders around the refill thresholds
      if ($urandom_range(3) == 0) begin
         echo = $urandom_range(0, ECHO_MAX);
      end else begin
         dist_walk = dist_walk + $urandom_range(0, 100) - 50;
         if (dist_walk < 0) dist_walk = 0;
         if (dist_walk > span) dist_walk = span;
         echo = dist_walk * 1000 / 17 + $urandom_range(0, 58);
         if (echo > ECHO_MAX) echo = ECHO_MAX;
      end
      send_sample(soil, temp, echo, light);
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.soil_raw  = '0;
      req_bus.temp_raw  = '0;
      req_bus.echo_us   = '0;
      req_bus.light_raw = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      sb                = new();
      sender_gap_pct    = 21;
      receiver_gap_pct  = 84;
      n_sent            = 0;
      n_settings        = 1;
      dist_walk         = 100;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: extremes, temperature band edges, dry and dim edges,
      // refill on, hold, off, hold
      send_sample(0, 0, 0, 0);
      send_sample(ADC_FULL, ADC_FULL, ECHO_MAX, ADC_FULL);
      send_sample(512, 122, 11765, ADC_FULL);
      send_sample(100, 123, 5882, 500);
      send_sample(100, 163, 1706, 322);
      send_sample(100, 164, 1765, 332);
      send_sample(100, 143, 11824, 323);
      send_sample(ADC_FULL, 143, 11824, 0);
      send_sample(343, 133, 5000, 331);
      send_sample(344, 133, 5000, 331);
      send_sample(343, 60, 3000, 700);
      send_sample(343, 60, 0, 200);
      send_sample(682, 341, 682, 341);
      send_sample(341, 682, 699050, 682);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p / 3)
            0:       begin sender_gap_pct = 21; receiver_gap_pct = 84; end
            1:       begin sender_gap_pct = 84; receiver_gap_pct = 21; end
            default: begin sender_gap_pct = 0;  receiver_gap_pct = 0;  end
         endcase
         if (p == 0) begin
            apply_settings(0, 0, 0, -128, 0);
         end else if (p == 4) begin
            apply_settings(127, 32767, 32767, 127, 255);
         end else if (p == 2 || p == 7) begin
            // crossed thresholds
            int low;
            low = $urandom_range(20, 400);
            apply_settings($urandom_range(10, 110), low, low + $urandom_range(1, 300),
                           int'($urandom_range(0, 111)) - LIGHT_OFFSET, $urandom_range(0, 255));
         end else if (p == PHASES - 1) begin
            apply_settings(40, 200, 30, 30, 55);
         end else begin
            int low;
            low = $urandom_range(50, 3000);
            apply_settings($urandom_range(10, 110), low, $urandom_range(0, low),
                           int'($urandom_range(0, 111)) - LIGHT_OFFSET, $urandom_range(0, 255));
         end
         dist_walk = sb.stop_cm;
         for (int k = 0; k < PHASE_ITEMS; k++) send_random_sample();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d sample sets sent, %0d results checked under %0d threshold settings",
               n_sent, sb.n_checked, n_settings);
      $display("%0d failing beats, %0d results still pending",
               sb.n_fail, sb.expected_controls.size());
      if (sb.n_fail == 0 && sb.expected_controls.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
